### rtl/vtp_pkg.sv
// ----------------------------------------------------------------------------
// vtp_pkg: shared types and constants
// Field widths, register indexes and the divider cell payload for the
// vertex transform and projection pipeline.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam int WORD_W  = 32;
  localparam int COEF_W  = 20;
  localparam int ROW_W   = 60;
  localparam int FOCAL_W = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  // d * |c| fits in 31 + 32 bits; the divisor |z'| in 32 bits.
  localparam int NUM_W = 63;
  localparam int DEN_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL     = 3'd6;

  // Side information that rides along the divider chain with each vertex.
  typedef struct packed {
    logic               zero;
    logic               clip;
    logic               neg_x;
    logic               neg_y;
    logic [WORD_W-1:0]  depth;
  } side_t;

  // Partial state of the two restoring divisions carried by one cell.
  typedef struct packed {
    logic [DEN_W:0]     rem_x;
    logic [DEN_W:0]     rem_y;
    logic [NUM_W-1:0]   num_x;
    logic [NUM_W-1:0]   num_y;
    logic [DEN_W-1:0]   den;
  } div_t;

endpackage

### rtl/vtp_div_cell.sv
// ----------------------------------------------------------------------------
// vtp_div_cell: one quotient-bit cell of the divider chain
// Performs one restoring step on both the x and y divisions and hands the
// partial remainder and shifted numerator to the next cell.
// ----------------------------------------------------------------------------
module vtp_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            valid_in,
  input  vtp_pkg::div_t   div_in,
  input  vtp_pkg::side_t  side_in,
  output logic            valid_out,
  output vtp_pkg::div_t   div_out,
  output vtp_pkg::side_t  side_out
);

  logic          valid_r;
  vtp_pkg::div_t div_r, div_nxt;
  vtp_pkg::side_t side_r;
  logic [vtp_pkg::DEN_W:0] tx, ty, dx, dy;

  always_comb begin
    // Shift the next numerator bit in; the quotient bit drops into the
    // vacated low bit of the numerator.
    tx = {div_in.rem_x[vtp_pkg::DEN_W-1:0], div_in.num_x[vtp_pkg::NUM_W-1]};
    ty = {div_in.rem_y[vtp_pkg::DEN_W-1:0], div_in.num_y[vtp_pkg::NUM_W-1]};
    dx = tx - {1'b0, div_in.den};
    dy = ty - {1'b0, div_in.den};
    div_nxt.den   = div_in.den;
    div_nxt.rem_x = dx[vtp_pkg::DEN_W] ? tx : dx;
    div_nxt.rem_y = dy[vtp_pkg::DEN_W] ? ty : dy;
    div_nxt.num_x = {div_in.num_x[vtp_pkg::NUM_W-2:0], ~dx[vtp_pkg::DEN_W]};
    div_nxt.num_y = {div_in.num_y[vtp_pkg::NUM_W-2:0], ~dy[vtp_pkg::DEN_W]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
    if (en) begin
      div_r  <= div_nxt;
      side_r <= side_in;
    end
  end

  assign valid_out = valid_r;
  assign div_out   = div_r;
  assign side_out  = side_r;

endmodule

### rtl/vtp_front.sv
// ----------------------------------------------------------------------------
// vtp_front: matrix transform and division setup
// Three stages: coefficient products, sum with rounding and saturation,
// then the focal products and divider operands.
// ----------------------------------------------------------------------------
module vtp_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic signed [31:0]            px,
  input  logic signed [31:0]            py,
  input  logic signed [31:0]            pz,
  input  logic [vtp_pkg::ROW_W-1:0]     row1,
  input  logic [vtp_pkg::ROW_W-1:0]     row2,
  input  logic [vtp_pkg::ROW_W-1:0]     row3,
  input  logic signed [31:0]            sh_x,
  input  logic signed [31:0]            sh_y,
  input  logic signed [31:0]            sh_z,
  input  logic [vtp_pkg::FOCAL_W-1:0]   focal,
  output logic                          valid_out,
  output vtp_pkg::div_t                 div_out,
  output vtp_pkg::side_t                side_out
);

  localparam int PROD_W = 52;
  localparam int ACC_W  = 56;

  logic signed [PROD_W-1:0] prod_r [9];
  logic signed [PROD_W-1:0] prod_nxt [9];
  logic signed [31:0] shx_r, shy_r, shz_r;
  logic v1_r, v2_r, v3_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_nxt[c]   = PROD_W'(px) * PROD_W'($signed(row1[c*20 +: 20]));
      prod_nxt[3+c] = PROD_W'(py) * PROD_W'($signed(row2[c*20 +: 20]));
      prod_nxt[6+c] = PROD_W'(pz) * PROD_W'($signed(row3[c*20 +: 20]));
    end
  end

  // Stage 2: sum, round half up, floor shift, saturate.
  logic signed [ACC_W-1:0] acc [3];
  logic signed [ACC_W-1:0] rs [3];
  logic signed [31:0] t_nxt [3];
  logic [2:0] clip_nxt;
  logic signed [31:0] shv [3];
  logic signed [31:0] t_r [3];
  logic [2:0] clip_r;

  always_comb begin
    shv[0] = shx_r; shv[1] = shy_r; shv[2] = shz_r;
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(prod_r[c]) + ACC_W'(prod_r[3+c]) + ACC_W'(prod_r[6+c])
             + (ACC_W'(shv[c]) <<< FRAC_BITS)
             + (ACC_W'(1) <<< (FRAC_BITS-1));
      rs[c] = acc[c] >>> FRAC_BITS;
      if (rs[c] > ACC_W'(32'sh7fffffff)) begin
        t_nxt[c] = 32'sh7fffffff; clip_nxt[c] = 1'b1;
      end else if (rs[c] < -(ACC_W'(33'sh080000000))) begin
        t_nxt[c] = 32'sh80000000; clip_nxt[c] = 1'b1;
      end else begin
        t_nxt[c] = rs[c][31:0]; clip_nxt[c] = 1'b0;
      end
    end
  end

  // Stage 3: focal products and operands.
  logic [31:0] mag_x, mag_y, mag_z;
  logic zero;
  vtp_pkg::div_t div_r, div_nxt;
  vtp_pkg::side_t side_r, side_nxt;

  always_comb begin
    mag_x = t_r[0][31] ? 32'(-t_r[0]) : 32'(t_r[0]);
    mag_y = t_r[1][31] ? 32'(-t_r[1]) : 32'(t_r[1]);
    mag_z = t_r[2][31] ? 32'(-t_r[2]) : 32'(t_r[2]);
    zero  = (t_r[2] == 32'sd0);
    div_nxt.rem_x = '0;
    div_nxt.rem_y = '0;
    div_nxt.num_x = 63'(focal) * 63'(mag_x);
    div_nxt.num_y = 63'(focal) * 63'(mag_y);
    div_nxt.den   = zero ? 32'd1 : mag_z;
    side_nxt.zero  = zero;
    side_nxt.clip  = clip_r[2] | (~zero & (clip_r[0] | clip_r[1]));
    side_nxt.neg_x = t_r[0][31] != ~t_r[2][31];
    side_nxt.neg_y = t_r[1][31] != ~t_r[2][31];
    side_nxt.depth = t_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_in; v2_r <= v1_r; v3_r <= v2_r;
    end
    if (en) begin
      prod_r <= prod_nxt;
      shx_r <= sh_x; shy_r <= sh_y; shz_r <= sh_z;
      t_r <= t_nxt;
      clip_r <= clip_nxt;
      div_r <= div_nxt;
      side_r <= side_nxt;
    end
  end

  assign valid_out = v3_r;
  assign div_out   = div_r;
  assign side_out  = side_r;

endmodule

### rtl/vertex_transform_and_project.sv
// ----------------------------------------------------------------------------
// vertex_transform_and_project: affine transform and perspective projection
// Row-vector times 3x3 matrix plus translation, then d*x'/(-z'), d*y'/(-z').
// ----------------------------------------------------------------------------
// Usage: each in_ beat carries one point (x, y, z, Q16.16). Each out_ beat
// carries screen x, screen y, depth and the zero-depth and saturated flags.
// The cfg_ channel writes a register by index; it is always ready. The user
// must write it only while the pipeline is empty; the block does not enforce it.
// Throughput is one vertex per cycle while the receiver does not stall. From
// input to output register there are three transform stages, then a chain of
// 63 divider cells, one quotient bit each, then the saturation stage.
// Reset clears all valid bits and loads the identity matrix, zero shift and
// a focal distance of 1.0. When the receiver stalls the whole pipeline
// holds; in_tready follows out_tready or an empty output register.
// ----------------------------------------------------------------------------
module vertex_transform_and_project #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,   // point_x, point_y, point_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [95:0]  out_tdata,  // screen_x, screen_y, depth
  output logic [7:0]   out_tuser,  // zero_depth, saturated, zero fill
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vtp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NCELL = vtp_pkg::NUM_W;

  logic [vtp_pkg::ROW_W-1:0] row1_r, row2_r, row3_r;
  logic [31:0] shx_r, shy_r, shz_r;
  logic [vtp_pkg::FOCAL_W-1:0] focal_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row1_r <= 60'd1 << FRAC_BITS;
      row2_r <= 60'd1 << (FRAC_BITS + 20);
      row3_r <= 60'd1 << (FRAC_BITS + 40);
      shx_r <= '0; shy_r <= '0; shz_r <= '0;
      focal_r <= 31'd1 << FRAC_BITS;
    end else if (cfg_valid) begin
      case (cfg_index)
        vtp_pkg::REG_ROW_ONE:   row1_r <= cfg_data[59:0];
        vtp_pkg::REG_ROW_TWO:   row2_r <= cfg_data[59:0];
        vtp_pkg::REG_ROW_THREE: row3_r <= cfg_data[59:0];
        vtp_pkg::REG_SHIFT_X:   shx_r <= cfg_data[31:0];
        vtp_pkg::REG_SHIFT_Y:   shy_r <= cfg_data[31:0];
        vtp_pkg::REG_SHIFT_Z:   shz_r <= cfg_data[31:0];
        vtp_pkg::REG_FOCAL:     focal_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = out_tready | ~out_tvalid;
  assign in_tready = en;

  logic           cv [NCELL+1];
  vtp_pkg::div_t  cd [NCELL+1];
  vtp_pkg::side_t cs [NCELL+1];

  vtp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .en,
    .valid_in(in_tvalid),
    .px(in_tdata[31:0]), .py(in_tdata[63:32]), .pz(in_tdata[95:64]),
    .row1(row1_r), .row2(row2_r), .row3(row3_r),
    .sh_x(shx_r), .sh_y(shy_r), .sh_z(shz_r), .focal(focal_r),
    .valid_out(cv[0]), .div_out(cd[0]), .side_out(cs[0])
  );

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    vtp_div_cell u_cell (
      .clk, .rst_n, .en,
      .valid_in(cv[i]), .div_in(cd[i]), .side_in(cs[i]),
      .valid_out(cv[i+1]), .div_out(cd[i+1]), .side_out(cs[i+1])
    );
  end

  // Sign and saturate the quotients.
  logic [vtp_pkg::NUM_W-1:0] qx, qy;
  logic [31:0] sx, sy;
  logic cx, cy;
  vtp_pkg::side_t se;
  logic vo_r;
  logic [95:0] data_r;
  logic [1:0] flag_r;

  always_comb begin
    qx = cd[NCELL].num_x;
    qy = cd[NCELL].num_y;
    se = cs[NCELL];
    cx = 1'b0; cy = 1'b0;
    if (se.neg_x) begin
      if (qx > 63'h80000000) begin sx = 32'h80000000; cx = 1'b1; end
      else sx = 32'(-qx);
    end else begin
      if (qx > 63'h7fffffff) begin sx = 32'h7fffffff; cx = 1'b1; end
      else sx = qx[31:0];
    end
    if (se.neg_y) begin
      if (qy > 63'h80000000) begin sy = 32'h80000000; cy = 1'b1; end
      else sy = 32'(-qy);
    end else begin
      if (qy > 63'h7fffffff) begin sy = 32'h7fffffff; cy = 1'b1; end
      else sy = qy[31:0];
    end
    if (se.zero) begin
      sx = '0; sy = '0; cx = 1'b0; cy = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= cv[NCELL];
    end
    if (en) begin
      data_r <= {se.depth, sy, sx};
      flag_r <= {se.clip | cx | cy, se.zero};
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = data_r;
  assign out_tuser  = {6'd0, flag_r};

endmodule

### rtl/vtp_checker.sv
// ----------------------------------------------------------------------------
// vtp_checker: port-level checks
// Output handshake and flag consistency seen at the top level.
// ----------------------------------------------------------------------------
module vtp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [7:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled beat changed");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[63:0] == 64'd0 &&
    out_tdata[95:64] == 32'd0)
    else $error("zero depth with nonzero screen values");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken during output stall");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tuser[7:2] == 6'd0)
    else $error("tuser fill bits set");

endmodule

bind vertex_transform_and_project vtp_checker u_vtp_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

### dv/vtp_checker.sv
// ----------------------------------------------------------------------------
// vtp_scoreboard: scoreboard for the vertex transform and projection block
// Tracks register writes, computes the expected screen point for every
// accepted vertex and compares each output beat against the oldest one.
// ----------------------------------------------------------------------------
module vtp_scoreboard (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [95:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [95:0]  out_tdata,
  input  logic [7:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [vtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vtp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int           mismatches,
  output int           outstanding,
  output int           points_seen,
  output int           zero_seen,
  output int           sat_seen
);

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] depth;
    logic        zero;
    logic        sat;
  } screen_pt_t;

  logic [vtp_pkg::ROW_W-1:0]   row_m [3];
  logic [vtp_pkg::WORD_W-1:0]  shift_m [3];
  logic [vtp_pkg::FOCAL_W-1:0] focal_m;
  screen_pt_t                  pending_pts[$];

  function automatic longint coef_of(logic [vtp_pkg::ROW_W-1:0] row, int col);
    logic signed [vtp_pkg::COEF_W-1:0] c;
    c = row[col*vtp_pkg::COEF_W +: vtp_pkg::COEF_W];
    return longint'(c);
  endfunction

  // Exact sum, round half up at the fraction point, clip to 32 bits.
  function automatic longint xform_coord(longint px, longint py, longint pz, int col,
                                         output bit clip);
    longint acc;
    acc = px * coef_of(row_m[0], col) + py * coef_of(row_m[1], col)
        + pz * coef_of(row_m[2], col)
        + (longint'($signed(shift_m[col])) <<< 16) + 64'sd32768;
    acc = acc >>> 16;
    clip = 0;
    if (acc > 64'sd2147483647) begin
      clip = 1;
      acc  = 64'sd2147483647;
    end else if (acc < -64'sd2147483648) begin
      clip = 1;
      acc  = -64'sd2147483648;
    end
    return acc;
  endfunction

  function automatic longint persp(longint c, longint z, output bit clip);
    longint unsigned mag, den, q;
    bit neg;
    mag  = (c < 0) ? -c : c;
    den  = (z < 0) ? -z : z;
    q    = longint'(focal_m) * mag / den;
    neg  = (c < 0) != (z > 0);
    clip = 0;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        clip = 1;
        return -64'sd2147483648;
      end
      return -longint'(q);
    end
    if (q > 64'h7FFF_FFFF) begin
      clip = 1;
      return 64'sd2147483647;
    end
    return longint'(q);
  endfunction

  function automatic screen_pt_t project_vertex(logic [95:0] pt);
    longint px, py, pz, tx, ty, tz, sx, sy;
    bit cx, cy, cz, csx, csy;
    screen_pt_t r;
    px = longint'($signed(pt[31:0]));
    py = longint'($signed(pt[63:32]));
    pz = longint'($signed(pt[95:64]));
    tx = xform_coord(px, py, pz, 0, cx);
    ty = xform_coord(px, py, pz, 1, cy);
    tz = xform_coord(px, py, pz, 2, cz);
    sx = 0;
    sy = 0;
    csx = 0;
    csy = 0;
    r.zero = (tz == 0);
    if (!r.zero) begin
      sx = persp(tx, tz, csx);
      sy = persp(ty, tz, csy);
    end
    r.sat   = cz || (!r.zero && (cx || cy || csx || csy));
    r.sx    = sx[31:0];
    r.sy    = sy[31:0];
    r.depth = tz[31:0];
    return r;
  endfunction

  assign outstanding = pending_pts.size();

  always @(posedge clk) begin
    screen_pt_t want;
    screen_pt_t got;
    if (!rst_n) begin
      row_m[0]   <= 60'd65536;
      row_m[1]   <= 60'd65536 << 20;
      row_m[2]   <= 60'd65536 << 40;
      shift_m[0] <= '0;
      shift_m[1] <= '0;
      shift_m[2] <= '0;
      focal_m    <= 31'd65536;
      mismatches  = 0;
      points_seen = 0;
      zero_seen   = 0;
      sat_seen    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vtp_pkg::REG_ROW_ONE:   row_m[0]   <= cfg_data[vtp_pkg::ROW_W-1:0];
          vtp_pkg::REG_ROW_TWO:   row_m[1]   <= cfg_data[vtp_pkg::ROW_W-1:0];
          vtp_pkg::REG_ROW_THREE: row_m[2]   <= cfg_data[vtp_pkg::ROW_W-1:0];
          vtp_pkg::REG_SHIFT_X:   shift_m[0] <= cfg_data[vtp_pkg::WORD_W-1:0];
          vtp_pkg::REG_SHIFT_Y:   shift_m[1] <= cfg_data[vtp_pkg::WORD_W-1:0];
          vtp_pkg::REG_SHIFT_Z:   shift_m[2] <= cfg_data[vtp_pkg::WORD_W-1:0];
          vtp_pkg::REG_FOCAL:     focal_m    <= cfg_data[vtp_pkg::FOCAL_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pending_pts = {pending_pts, project_vertex(in_tdata)};
        points_seen++;
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
               out_tuser[0], out_tuser[1]};
        if (pending_pts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: output beat with nothing expected: %h", got);
        end else begin
          want = pending_pts.pop_front();
          zero_seen += want.zero;
          sat_seen  += want.sat;
          if (got.sx !== want.sx || got.sy !== want.sy || got.depth !== want.depth ||
              got.zero !== want.zero || got.sat !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: sx %h/%h sy %h/%h depth %h/%h zero %b/%b sat %b/%b (exp/got)",
                       want.sx, got.sx, want.sy, got.sy, want.depth, got.depth,
                       want.zero, got.zero, want.sat, got.sat);
          end
        end
      end
    end
  end

endmodule

### dv/vertex_transform_and_project_tb.sv
// ----------------------------------------------------------------------------
// vertex_transform_and_project_tb: stimulus and verdict
// Sweeps matrix, translation and focal settings, sends directed edge points
// and random vertices under varying source gaps and sink backpressure.
// ----------------------------------------------------------------------------
module vertex_transform_and_project_tb;

  localparam int CYCLE_LIMIT = 600000;
  // An index that names no register; writes to it are dropped.
  localparam logic [vtp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic [7:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [vtp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vtp_pkg::CFG_DATA_W-1:0] cfg_data;

  int mismatches, outstanding, points_seen, zero_seen, sat_seen;
  int idle_pct, stall_pct, cycles, cfg_writes;

  vertex_transform_and_project i_dut (.*);

  vtp_scoreboard i_checker (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= stall_pct);

  task automatic write_reg(logic [vtp_pkg::CFG_IDX_W-1:0] idx,
                           logic [vtp_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [19:0] rand_coef();
    case ($urandom_range(3))
      0:       return 20'h7FFFF;
      1:       return 20'h80000;
      2:       return 20'($signed($urandom_range(131072)) - 65536);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
      default: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
    endcase
  endfunction

  task automatic load_random_setup();
    write_reg(vtp_pkg::REG_ROW_ONE,   {4'd0, rand_coef(), rand_coef(), rand_coef()});
    write_reg(vtp_pkg::REG_ROW_TWO,   {4'd0, rand_coef(), rand_coef(), rand_coef()});
    write_reg(vtp_pkg::REG_ROW_THREE, {4'd0, rand_coef(), rand_coef(), rand_coef()});
    write_reg(vtp_pkg::REG_SHIFT_X, 64'(rand_coord()));
    write_reg(vtp_pkg::REG_SHIFT_Y, 64'(rand_coord()));
    write_reg(vtp_pkg::REG_SHIFT_Z, 64'(rand_coord()));
    write_reg(vtp_pkg::REG_FOCAL,
              64'($urandom_range(1, 31'h7FFFFFFF) >> $urandom_range(30)));
  endtask

  initial begin
    int idle_tab [4];
    int stall_tab [4];
    idle_tab  = '{0, 58, 0, 32};
    stall_tab = '{0, 0, 58, 32};
    cfg_writes = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Identity setup: zero depth, exact extremes and sign corners.
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
    send_point(32'h0, 32'h0, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h7FFF_FFFF);
    drain();

    // Largest coefficients and shifts: clipping of every coordinate.
    write_reg(vtp_pkg::REG_ROW_ONE,   60'h7FFFF_7FFFF_7FFFF);
    write_reg(vtp_pkg::REG_ROW_TWO,   60'h80000_80000_80000);
    write_reg(vtp_pkg::REG_ROW_THREE, 60'h7FFFF_80000_7FFFF);
    write_reg(vtp_pkg::REG_SHIFT_X, 64'h7FFF_FFFF);
    write_reg(vtp_pkg::REG_SHIFT_Y, 64'h8000_0000);
    write_reg(vtp_pkg::REG_SHIFT_Z, 64'h8000_0000);
    write_reg(vtp_pkg::REG_FOCAL, 64'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
    drain();

    // Near-zero matrix, smallest focal distance, unknown register index.
    write_reg(vtp_pkg::REG_ROW_ONE, 64'hFFFF_0000_0000_0000);
    write_reg(vtp_pkg::REG_ROW_TWO, 64'h0);
    write_reg(vtp_pkg::REG_ROW_THREE, 64'h0);
    write_reg(vtp_pkg::REG_SHIFT_X, 64'hFFFF_FFFF_0001_0000);
    write_reg(vtp_pkg::REG_SHIFT_Y, 64'h8000_0000);
    write_reg(vtp_pkg::REG_SHIFT_Z, 64'h0);
    write_reg(vtp_pkg::REG_FOCAL, 64'hFFFF_FFFF_8000_0001);
    write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    write_reg(vtp_pkg::REG_SHIFT_Z, 64'hFFFF_FFFF);
    send_point(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();

    // Random part: four pacing phases, a fresh setup every 96 vertices.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (int blk = 0; blk < 4; blk++) begin
        drain();
        load_random_setup();
        for (int n = 0; n < 96; n++)
          send_point(rand_coord(), rand_coord(),
                     ($urandom_range(15) == 0) ? 32'($urandom_range(3)) : rand_coord());
      end
    end
    in_tvalid <= 1'b0;
    stall_pct = 20;

    while (outstanding != 0) @(negedge clk);
    repeat (80) @(negedge clk);

    $display("Covered %0d vertices over %0d register writes and four pacing phases;",
             points_seen, cfg_writes);
    $display("%0d results had zero depth and %0d were clipped.", zero_seen, sat_seen);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
